### src/adc_trimmed_mean_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trimmed mean filter core
// Implication checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ADC_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH
`define ADC_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define ADCTMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adctmf assertion failed");

// next-cycle implication
`define ADCTMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adctmf assertion failed");

`endif

### src/adctmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adctmf_pkg
// Shared constants, register indexes and types of the trimmed mean filter.
// ----------------------------------------------------------------------------
package adctmf_pkg;

    localparam int BURST_LEN  = 8;
    localparam int CNT_W      = $clog2(BURST_LEN);
    localparam int MID_FIRST  = (BURST_LEN / 2) - 2;
    localparam int WORD_W     = 14;
    localparam int SAMPLE_W   = 13;
    localparam int SIGN_POS   = 13;
    localparam int RESULT_W   = 15;
    localparam int REF_W      = 12;
    localparam int UNIT_W     = 16;
    localparam int PROD_W     = RESULT_W + REF_W;
    localparam int SCALE_SH   = 12;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [REF_W-1:0] REF_MV_RESET = REF_W'(1175);

    localparam logic REG_REF_MV   = 1'b0;
    localparam logic REG_RAW_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SUM,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [REF_W-1:0] ref_mv;
        logic             raw_mode;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [RESULT_W-1:0] value;
    } seq_res_t;

endpackage

### src/adctmf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adctmf_cfg
// APB register file: reference in millivolts and raw mode select.
// ----------------------------------------------------------------------------
module adctmf_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adctmf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [adctmf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [adctmf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    output adctmf_pkg::cfg_t                   cfg
);
    import adctmf_pkg::*;

    logic [REF_W-1:0] ref_mv_reg, ref_mv_next;
    logic             raw_mode_reg, raw_mode_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        ref_mv_next   = ref_mv_reg;
        raw_mode_next = raw_mode_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_REF_MV:   ref_mv_next   = pwdata[REF_W-1:0];
                REG_RAW_MODE: raw_mode_next = pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_REF_MV:   prdata = APB_DATA_W'(ref_mv_reg);
            REG_RAW_MODE: prdata = APB_DATA_W'(raw_mode_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_mv_reg   <= REF_MV_RESET;
            raw_mode_reg <= 1'b0;
        end else begin
            ref_mv_reg   <= ref_mv_next;
            raw_mode_reg <= raw_mode_next;
        end
    end

    assign cfg.ref_mv   = ref_mv_reg;
    assign cfg.raw_mode = raw_mode_reg;

endmodule

### src/adctmf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adctmf_seq
// Sorted sample store with one shared add/subtract unit under a sequencer:
// insertion sort step by step, middle-four sum, optional scaling multiply.
// ----------------------------------------------------------------------------
module adctmf_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  logic [adctmf_pkg::WORD_W-1:0]   in_word,
    input  adctmf_pkg::cfg_t                cfg,
    input  logic                            out_free,
    output logic                            in_ready,
    output adctmf_pkg::seq_res_t            seq_res
);
    import adctmf_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BURST_LEN - 1);
    localparam logic [CNT_W-1:0] MID_IDX  = CNT_W'(MID_FIRST);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [1:0]            nsum_reg, nsum_next;
    logic [SAMPLE_W-1:0]   samp_reg, samp_next;
    logic [RESULT_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  raw_sel_reg, raw_sel_next;

    logic [SAMPLE_W-1:0]   store_reg [BURST_LEN];
    logic                  wr_en;
    logic [CNT_W-1:0]      wr_addr;
    logic [SAMPLE_W-1:0]   wr_data;
    logic [CNT_W-1:0]      rd_addr;
    logic [SAMPLE_W-1:0]   rd_data;

    logic [UNIT_W-1:0]     unit_a, unit_b, unit_res;
    logic                  unit_sub;

    assign rd_data  = store_reg[rd_addr];
    assign unit_res = unit_a + (unit_sub ? ~unit_b : unit_b) + UNIT_W'(unit_sub);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        nsum_next    = nsum_reg;
        samp_next    = samp_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        raw_sel_next = raw_sel_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = samp_reg;
        rd_addr      = pos_reg - CNT_W'(1);
        unit_a       = UNIT_W'(samp_reg);
        unit_b       = UNIT_W'(rd_data);
        unit_sub     = 1'b1;
        in_ready     = 1'b0;
        seq_res.valid = 1'b0;
        seq_res.value = raw_sel_reg ? acc_reg : prod_reg[PROD_W-1:SCALE_SH];

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    samp_next  = in_word[SIGN_POS] ? '0 : in_word[SAMPLE_W-1:0];
                    pos_next   = count_reg;
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                wr_en = 1'b1;
                if (pos_reg != '0 && unit_res[UNIT_W-1]) begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - CNT_W'(1);
                end else if (count_reg == LAST_CNT) begin
                    count_next = '0;
                    idx_next   = MID_IDX;
                    nsum_next  = '0;
                    acc_next   = '0;
                    state_next = ST_SUM;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                rd_addr   = idx_reg;
                unit_a    = UNIT_W'(acc_reg);
                unit_sub  = 1'b0;
                acc_next  = unit_res[RESULT_W-1:0];
                idx_next  = idx_reg + CNT_W'(1);
                nsum_next = nsum_reg + 2'd1;
                if (nsum_reg == 2'd3) begin
                    raw_sel_next = cfg.raw_mode;
                    state_next   = cfg.raw_mode ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(acc_reg) * PROD_W'(cfg.ref_mv);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                seq_res.valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        nsum_reg    <= nsum_next;
        samp_reg    <= samp_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        raw_sel_reg <= raw_sel_next;
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

endmodule

### src/adc_trimmed_mean_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_trimmed_mean_filter_core
// Trimmed mean of 8-word ADC bursts: sort, sum middle four, optionally scale.
// ----------------------------------------------------------------------------
// Usage:
//   s_ stream takes one raw ADC word per transaction; a word with its sign
//   bit set enters as zero. Each word is sorted into the store by a shared
//   compare unit, one stored sample per cycle, so a word keeps s_tready low
//   until it has been shifted into place. The eighth word of a burst
//   produces one m_ transaction: the middle four samples are summed through
//   the same unit, the sum is multiplied by ref_millivolts unless raw_mode
//   is set, then the result is handed to the output register. Other words
//   produce no result.
//   APB registers: ref_millivolts at 0x0, raw_mode at 0x4; write them only
//   while the block is idle.
//   Reset clears the burst count, the output valid flag and the registers
//   to their defaults. If the receiver stalls, the result holds in the
//   output register and input keeps flowing until the next result is
//   ready; the sequencer then waits with s_tready low.
// ----------------------------------------------------------------------------
module adc_trimmed_mean_filter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [13:0] adc_word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [14:0] result_value
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adctmf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [adctmf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [adctmf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import adctmf_pkg::*;

    `include "adc_trimmed_mean_filter_core_assert.svh"

    cfg_t                cfg;
    seq_res_t            seq_res;
    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [RESULT_W-1:0] m_value_reg, m_value_next;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = seq_res.valid && out_free;

    adctmf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adctmf_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_word   (s_tdata[WORD_W-1:0]),
        .cfg       (cfg),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .seq_res   (seq_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_value_next  = m_value_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_value_next  = seq_res.value;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(m_value_reg);

    `ADCTMF_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready)
    `ADCTMF_ASSERT_NEXT(a_result_held, seq_res.valid && !out_free, seq_res.valid)
    `ADCTMF_ASSERT_NOW(a_no_accept_with_result, seq_res.valid, !s_tready)
    `ADCTMF_ASSERT_NEXT(a_load_sets_valid, out_load, m_tvalid)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the trimmed mean filter core. A directed table of
// bursts (sign handling, full-scale words, descending order, equal samples)
// is followed by random bursts under several register settings and idling
// patterns. Every accepted word passes through a sorting model of the
// filter, and each m_ transaction is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
    import adctmf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 20;
    localparam int RAND_PHASES  = 8;
    localparam int DIR_ROWS     = 27;

    localparam logic [APB_ADDR_W-1:0] ADDR_REF_MV   = {REG_REF_MV, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_RAW_MODE = {REG_RAW_MODE, 2'b00};

    typedef struct packed {
        bit                    is_reg;
        logic [APB_ADDR_W-1:0] addr;
        logic [APB_DATA_W-1:0] wdata;
        logic [WORD_W-1:0]     word;
        bit                    typed;
        logic [RESULT_W-1:0]   want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;   // [13:0] adc_word
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [14:0] result_value
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    logic [REF_W-1:0]    cfg_ref_mv = REF_MV_RESET;
    logic                cfg_raw    = 1'b0;
    logic [SAMPLE_W-1:0] burst_sorted [BURST_LEN];
    int unsigned         burst_fill = 0;
    logic [RESULT_W-1:0] pending_sums [$];

    stim_row_t dir_table [DIR_ROWS] = '{
        // negative readings sort as zero, full-scale words fill the middle
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h2000, 1'b0, '0},
        '{1'b0, '0, '0, 14'h3FFF, 1'b1, 15'd9398},
        '{1'b1, ADDR_RAW_MODE, 32'd1, '0, 1'b0, '0},
        // descending words, each insertion shifts the whole store
        '{1'b0, '0, '0, 14'd8, 1'b0, '0},
        '{1'b0, '0, '0, 14'd7, 1'b0, '0},
        '{1'b0, '0, '0, 14'd6, 1'b0, '0},
        '{1'b0, '0, '0, 14'd5, 1'b0, '0},
        '{1'b0, '0, '0, 14'd4, 1'b0, '0},
        '{1'b0, '0, '0, 14'd3, 1'b0, '0},
        '{1'b0, '0, '0, 14'd2, 1'b0, '0},
        '{1'b0, '0, '0, 14'd1, 1'b1, 15'd18},
        '{1'b1, ADDR_REF_MV, 32'd4095, '0, 1'b0, '0},
        '{1'b1, ADDR_RAW_MODE, 32'd0, '0, 1'b0, '0},
        // equal samples at full scale, largest reference
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b0, '0},
        '{1'b0, '0, '0, 14'h1FFF, 1'b1, 15'd32756}
    };

    adc_trimmed_mean_filter_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, m_tdata[RESULT_W-1:0]);
                fail_count++;
            end else if (m_tdata[RESULT_W-1:0] !== pending_sums[0]) begin
                $display("%0t: result_value mismatch, expected %0d, actual %0d",
                         $time, pending_sums[0], m_tdata[RESULT_W-1:0]);
                fail_count++;
                void'(pending_sums.pop_front());
            end else begin
                void'(pending_sums.pop_front());
            end
        end
    end

    task automatic trimmed_mean_insert(input logic [WORD_W-1:0] word, output bit done,
                                       output logic [RESULT_W-1:0] value);
        logic [SAMPLE_W-1:0] smp;
        int                  pos;
        int unsigned         total;
        smp = word[SIGN_POS] ? '0 : word[SAMPLE_W-1:0];
        if (burst_fill >= BURST_LEN) begin
            burst_fill = 0;
        end
        pos = burst_fill;
        while (pos > 0 && burst_sorted[pos-1] > smp) begin
            burst_sorted[pos] = burst_sorted[pos-1];
            pos--;
        end
        burst_sorted[pos] = smp;
        burst_fill++;
        done = 1'b0;
        value = '0;
        if (burst_fill == BURST_LEN) begin
            total = 0;
            for (int i = 0; i < 4; i++) begin
                total += burst_sorted[MID_FIRST+i];
            end
            value = cfg_raw ? total[RESULT_W-1:0]
                            : RESULT_W'((total * cfg_ref_mv) >> SCALE_SH);
            burst_fill = 0;
            done = 1'b1;
        end
    endtask

    task automatic send_word(input logic [WORD_W-1:0] word, input bit typed,
                             input logic [RESULT_W-1:0] want);
        bit                  done;
        logic [RESULT_W-1:0] value;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        s_tdata  <= {2'b00, word};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        trimmed_mean_insert(word, done, value);
        if (done) begin
            pending_sums.push_back(typed ? want : value);
        end
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[APB_ADDR_W-1:2] == REG_REF_MV) begin
            cfg_ref_mv = data[REF_W-1:0];
        end else if (addr[APB_ADDR_W-1:2] == REG_RAW_MODE) begin
            cfg_raw = data[0];
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1:    return {1'b1, SAMPLE_W'($urandom)};
            2:       return WORD_W'(14'h1FFF);
            3:       return '0;
            4, 5:    return WORD_W'($urandom_range(0, 3));
            6, 7, 8: return WORD_W'($urandom);
            default: return {1'b0, SAMPLE_W'($urandom)};
        endcase
    endfunction

    initial begin
        int unsigned n_items;
        logic [REF_W-1:0] ref_val;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            if (dir_table[i].is_reg) begin
                write_reg(dir_table[i].addr, dir_table[i].wdata);
            end else begin
                send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       ref_val = '0;
                1:       ref_val = '1;
                3:       ref_val = REF_W'(1);
                default: ref_val = REF_W'($urandom_range(0, 4095));
            endcase
            write_reg(ADDR_REF_MV, APB_DATA_W'(ref_val));
            write_reg(ADDR_RAW_MODE, APB_DATA_W'(p == 2 || p == 5));
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 82; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 82; end
                default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
            endcase
            n_items = $urandom_range(70, 80);
            for (int k = 0; k < n_items; k++) begin
                send_word(pick_word(), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
